// ===== rtl/gcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types and constants for the greedy change maker with coin stock.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int MAX_DENOMS = 8;
  localparam int IDX_W      = $clog2(MAX_DENOMS);
  localparam int CNT_W      = $clog2(MAX_DENOMS + 1);
  localparam int VAL_W      = 16;
  localparam int STOCK_W    = 8;
  localparam int PROD_W     = VAL_W + STOCK_W;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [STOCK_W-1:0] stock_t;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // One denomination table entry
  typedef struct packed {
    stock_t stock;
    val_t   value;
  } denom_entry_t;

  localparam int ENTRY_W = $bits(denom_entry_t);

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic done;
    val_t quotient;
  } div_status_t;

endpackage

// ===== rtl/gcm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module gcm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/gcm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_div
// Restoring radix-2 divider: one quotient bit per cycle; done is registered
// together with the last quotient bit.
// ----------------------------------------------------------------------------
module gcm_div
  import gcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  val_t        dividend,
  input  val_t        divisor,
  output div_status_t status
);

  localparam int STEP_W = $clog2(VAL_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  val_t              acc;
  val_t              quo;
  val_t              dvs;
  logic              done;

  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {acc, quo[VAL_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        acc  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[VAL_W]) begin
          acc <= diff[VAL_W-1:0];
          quo <= {quo[VAL_W-2:0], 1'b1};
        end else begin
          acc <= trial[VAL_W-1:0];
          quo <= {quo[VAL_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == STEP_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done     = done;
  assign status.quotient = quo;

endmodule

// ===== rtl/greedy_change_maker_limited_stock_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_maker_limited_stock_core
// Greedy change maker over a table of coin denominations with limited stock.
// Loads fill a table RAM; a request walks it from the top entry down, divides
// the remainder by each nonzero value, stores the coins used in a second RAM,
// then streams one result per entry in index order (one if the table is empty).
//
//   Channel  Dir  Transfer when         Payload
//   s_*      in   s_tvalid & s_tready  tuser=cmd, tdata=value/stock/target
//   m_*      out  m_tvalid & m_tready  tdata=index/used/success, tlast
//
// A request sends each entry with a nonzero value through RAM read, check,
// the 16-step divider and multiply-subtract, and each zero-value entry through
// read and check only; each result then takes a RAM read and an output load.
// Input is taken only while no request is in progress. Reset (rst,
// synchronous) empties the table; RAM contents are not cleared. A stalled
// output holds the sequencer in the emit phase.
// ----------------------------------------------------------------------------
module greedy_change_maker_limited_stock_core
  import gcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // coin_value[15:0], coin_stock[23:16], target_amount[39:24]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // entry_index[2:0], used_count[10:3], success[11], zero
  output logic        m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_WALK_DIV,
    ST_WALK_MUL,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_EMIT_EMPTY
  } state_t;

  state_t       state;
  cnt_t         entry_count;
  val_t         remaining;
  idx_t         walk_idx;
  idx_t         emit_idx;
  val_t         cur_value;
  stock_t       cur_stock;
  stock_t       use_cnt;

  logic         in_xfer;
  cmd_t         cmd;
  val_t         in_value;
  stock_t       in_stock;
  val_t         in_target;

  logic         tbl_wr_en;
  denom_entry_t tbl_wr_data;
  denom_entry_t tbl_rd_data;
  logic [ENTRY_W-1:0] tbl_rd_raw;

  logic         used_wr_en;
  stock_t       used_wr_data;
  stock_t       used_rd_data;

  logic         div_start;
  div_status_t  div_stat;

  logic [PROD_W-1:0] product;
  stock_t       quo_sat;
  logic         out_free;
  logic         out_load;
  logic         emit_last;

  idx_t         out_idx;
  stock_t       out_used;
  logic         out_ok;

  // Unpack the input transfer
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign cmd       = cmd_t'(s_tuser);
  assign in_value  = s_tdata[15:0];
  assign in_stock  = s_tdata[23:16];
  assign in_target = s_tdata[39:24];

  // Table RAM: append on load, read at the walk pointer
  assign tbl_wr_en         = in_xfer && (cmd == CMD_LOAD) &&
                             (entry_count < CNT_W'(MAX_DENOMS));
  assign tbl_wr_data.value = in_value;
  assign tbl_wr_data.stock = in_stock;
  assign tbl_rd_data       = denom_entry_t'(tbl_rd_raw);

  gcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_DENOMS)
  ) u_table_ram (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (tbl_wr_data),
    .rd_addr (walk_idx),
    .rd_data (tbl_rd_raw)
  );

  // Used-count RAM: written by the walk, read by the emit phase
  always_comb begin
    used_wr_en   = 1'b0;
    used_wr_data = use_cnt;
    if (state == ST_WALK_CHK && tbl_rd_data.value == '0) begin
      used_wr_en   = 1'b1;
      used_wr_data = tbl_rd_data.stock;
    end else if (state == ST_WALK_MUL) begin
      used_wr_en   = 1'b1;
    end
  end

  gcm_ram #(
    .WIDTH (STOCK_W),
    .DEPTH (MAX_DENOMS)
  ) u_used_ram (
    .clk     (clk),
    .wr_en   (used_wr_en),
    .wr_addr (walk_idx),
    .wr_data (used_wr_data),
    .rd_addr (emit_idx),
    .rd_data (used_rd_data)
  );

  // Divider for remainder / value
  assign div_start = (state == ST_WALK_CHK) && (tbl_rd_data.value != '0);

  gcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (remaining),
    .divisor  (tbl_rd_data.value),
    .status   (div_stat)
  );

  // Clamp the quotient to the stock, then take the coins off the remainder
  always_comb begin
    quo_sat = (div_stat.quotient > VAL_W'(cur_stock)) ? cur_stock
                                                       : div_stat.quotient[STOCK_W-1:0];
    product = PROD_W'(use_cnt) * PROD_W'(cur_value);
  end

  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && ((state == ST_EMIT_OUT) || (state == ST_EMIT_EMPTY));
  assign emit_last = (CNT_W'(emit_idx) + 1'b1) == entry_count;

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      remaining   <= '0;
      walk_idx    <= '0;
      emit_idx    <= '0;
      m_tvalid    <= 1'b0;
      m_tlast     <= 1'b0;
    end else begin
      // load a new result or drop the one just taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (cmd)
              CMD_CLEAR: entry_count <= '0;
              CMD_LOAD: begin
                if (tbl_wr_en) begin
                  entry_count <= entry_count + 1'b1;
                end
              end
              CMD_REQUEST: begin
                remaining <= in_target;
                emit_idx  <= '0;
                if (entry_count == '0) begin
                  state <= ST_EMIT_EMPTY;
                end else begin
                  walk_idx <= IDX_W'(entry_count - 1'b1);
                  state    <= ST_WALK_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK_RD: state <= ST_WALK_CHK;
        ST_WALK_CHK: begin
          cur_value <= tbl_rd_data.value;
          cur_stock <= tbl_rd_data.stock;
          if (tbl_rd_data.value == '0) begin
            // zero value: whole stock used, remainder unchanged
            if (walk_idx == '0) begin
              state <= ST_EMIT_RD;
            end else begin
              walk_idx <= walk_idx - 1'b1;
              state    <= ST_WALK_RD;
            end
          end else begin
            state <= ST_WALK_DIV;
          end
        end
        ST_WALK_DIV: begin
          if (div_stat.done) begin
            use_cnt <= quo_sat;
            state   <= ST_WALK_MUL;
          end
        end
        ST_WALK_MUL: begin
          remaining <= remaining - product[VAL_W-1:0];
          if (walk_idx == '0) begin
            state <= ST_EMIT_RD;
          end else begin
            walk_idx <= walk_idx - 1'b1;
            state    <= ST_WALK_RD;
          end
        end
        ST_EMIT_RD: state <= ST_EMIT_OUT;
        ST_EMIT_OUT: begin
          if (out_free) begin
            out_idx  <= emit_idx;
            out_used <= used_rd_data;
            out_ok   <= (remaining == '0);
            m_tlast  <= emit_last;
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= ST_EMIT_RD;
            end
          end
        end
        ST_EMIT_EMPTY: begin
          if (out_free) begin
            out_idx  <= '0;
            out_used <= '0;
            out_ok   <= (remaining == '0);
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'b0, out_ok, out_used, out_idx};

endmodule

// ===== tb/greedy_change_maker_limited_stock_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_maker_limited_stock_core_tb
// Self-checking bench for the greedy change maker core. Commands go in on the
// slave stream and results come out on the master stream, with random gaps on
// both sides. A local model of the coin table predicts every result record,
// and the monitor compares each output transfer field by field in order.
// ----------------------------------------------------------------------------
module greedy_change_maker_limited_stock_core_tb;
  import gcm_pkg::*;

  localparam int ITEMS_TOTAL = 330;
  localparam int DRAIN_CYCLES = 250;
  localparam int LONG_HOLD = 700;

  // One expected output record
  typedef struct packed {
    idx_t   idx;
    stock_t used;
    logic   ok;
    logic   fin;
  } change_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // coin_value[15:0], coin_stock[23:16], target_amount[39:24]
  logic [1:0]  s_tuser = CMD_NONE;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // entry_index[2:0], used_count[10:3], success[11], zero
  logic        m_tlast;

  // Local copy of the coin table
  val_t        coin_val_tbl[MAX_DENOMS];
  stock_t      coin_stk_tbl[MAX_DENOMS];
  int          coin_cnt = 0;

  change_rec_t change_q[$];
  int          mismatch_cnt = 0;
  int          items_sent = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold_req = 0;

  greedy_change_maker_limited_stock_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap(bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Append one expected record at the tail
  task automatic add_expected(change_rec_t rec);
    change_q.insert(change_q.size(), rec);
  endtask

  // Update the table and queue the change records for one accepted transfer
  task automatic predict_change(cmd_t cmd, val_t value, stock_t stock, val_t target);
    val_t        rem;
    logic [31:0] quot;
    logic [31:0] take;
    stock_t      used[MAX_DENOMS];
    change_rec_t rec;
    int          e;
    case (cmd)
      CMD_CLEAR: begin
        coin_cnt = 0;
      end
      CMD_LOAD: begin
        if (coin_cnt < MAX_DENOMS) begin
          coin_val_tbl[coin_cnt] = value;
          coin_stk_tbl[coin_cnt] = stock;
          coin_cnt++;
        end
      end
      CMD_REQUEST: begin
        rem = target;
        if (coin_cnt == 0) begin
          rec.idx  = '0;
          rec.used = '0;
          rec.ok   = (target == '0);
          rec.fin  = 1'b1;
          add_expected(rec);
        end else begin
          // Walk from the top entry down
          for (e = coin_cnt - 1; e >= 0; e--) begin
            if (coin_val_tbl[e] == '0) begin
              take = coin_stk_tbl[e];
            end else begin
              quot = 32'(rem) / 32'(coin_val_tbl[e]);
              take = (quot < 32'(coin_stk_tbl[e])) ? quot : 32'(coin_stk_tbl[e]);
              rem  = val_t'(32'(rem) - take * 32'(coin_val_tbl[e]));
            end
            used[e] = stock_t'(take);
          end
          // Report in index order
          for (e = 0; e < coin_cnt; e++) begin
            rec.idx  = idx_t'(e);
            rec.used = used[e];
            rec.ok   = (rem == '0);
            rec.fin  = (e == coin_cnt - 1);
            add_expected(rec);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offer one command and hold it until the transfer
  task automatic send_item(cmd_t cmd, val_t value, stock_t stock, val_t target);
    int gap;
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {target, stock, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_change(cmd, value, stock, target);
    if (cmd != CMD_NONE) items_sent++;
  endtask

  // Drop valid and wait until every expected record has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (change_q.size() != 0) @(posedge clk);
  endtask

  // Requests on an empty table, plus the unused command code
  task automatic test_empty_table();
    send_item(CMD_REQUEST, 16'h0000, 8'h00, 16'h0000);
    send_item(CMD_REQUEST, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(CMD_NONE, 16'h1234, 8'h56, 16'h789A);
  endtask

  // A small ordinary coin set
  task automatic test_basic_set();
    send_item(CMD_CLEAR, 16'h0000, 8'h00, 16'h0000);
    send_item(CMD_LOAD, 16'd1, 8'd4, 16'h0000);
    send_item(CMD_LOAD, 16'd5, 8'd3, 16'h0000);
    send_item(CMD_LOAD, 16'd25, 8'd2, 16'h0000);
    send_item(CMD_REQUEST, 16'h0000, 8'h00, 16'd67);
    send_item(CMD_REQUEST, 16'h0000, 8'h00, 16'd500);
  endtask

  // Full table with a zero value, a zero stock, a duplicate, an out-of-order
  // value and the extremes, then one load past the end
  task automatic test_full_table();
    send_item(CMD_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(CMD_LOAD, 16'd0, 8'd5, 16'h0000);
    send_item(CMD_LOAD, 16'd1, 8'd255, 16'h0000);
    send_item(CMD_LOAD, 16'd7, 8'd0, 16'h0000);
    send_item(CMD_LOAD, 16'd7, 8'd3, 16'h0000);
    send_item(CMD_LOAD, 16'd100, 8'd10, 16'h0000);
    send_item(CMD_LOAD, 16'd40, 8'd2, 16'h0000);
    send_item(CMD_LOAD, 16'd1000, 8'd1, 16'h0000);
    send_item(CMD_LOAD, 16'hFFFF, 8'd255, 16'h0000);
    send_item(CMD_LOAD, 16'hAAAA, 8'd9, 16'h0000);
    send_item(CMD_REQUEST, 16'h0000, 8'h00, 16'hFFFF);
    send_item(CMD_REQUEST, 16'h0000, 8'h00, 16'h0000);
  endtask

  // Stall the output long enough to block the input, then pause until drained
  task automatic test_backpressure();
    int k;
    wait_drain();
    tx_idle_en = 1'b0;
    send_item(CMD_CLEAR, 16'h0000, 8'h00, 16'h0000);
    for (k = 0; k < MAX_DENOMS; k++)
      send_item(CMD_LOAD, val_t'(1 << k), stock_t'($urandom_range(1, 20)), 16'h0000);
    rx_hold_req = LONG_HOLD;
    repeat (5) send_item(CMD_REQUEST, 16'h0000, 8'h00, val_t'($urandom_range(0, 3000)));
    wait_drain();
    tx_idle_en = 1'b1;
  endtask

  // Random sessions: mostly clear, ascending loads and requests; some noise
  task automatic test_random_sessions();
    int          n_load;
    int          k;
    int          pick;
    logic [31:0] acc;
    logic [31:0] nxt;
    stock_t      stk;
    val_t        tgt;
    val_t        sess_val[MAX_DENOMS];
    stock_t      sess_stk[MAX_DENOMS];
    logic [1:0]  raw_cmd;
    while (items_sent < ITEMS_TOTAL) begin
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 9) != 0)
          send_item(CMD_CLEAR, val_t'($urandom), stock_t'($urandom), val_t'($urandom));
        n_load = $urandom_range(1, MAX_DENOMS);
        acc = $urandom_range(0, 20);
        for (k = 0; k < n_load; k++) begin
          stk = ($urandom_range(0, 1) != 0) ? stock_t'($urandom_range(0, 255))
                                            : stock_t'($urandom_range(0, 12));
          sess_val[k] = val_t'(acc);
          sess_stk[k] = stk;
          send_item(CMD_LOAD, val_t'(acc), stk, val_t'($urandom));
          case ($urandom_range(0, 2))
            0: nxt = acc + $urandom_range(1, 4);
            1: nxt = acc + $urandom_range(1, 60);
            default: nxt = acc + $urandom_range(1, 9000);
          endcase
          acc = (nxt > 32'hFFFF) ? 32'hFFFF : nxt;
        end
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(0, 99);
          if (pick < 50) begin
            // Target built from coins that exist
            acc = 0;
            for (k = 0; k < n_load; k++)
              acc += $urandom_range(0, sess_stk[k]) * sess_val[k];
            tgt = (acc > 32'hFFFF) ? val_t'($urandom) : val_t'(acc);
          end else if (pick < 80) begin
            tgt = val_t'($urandom_range(0, 500));
          end else begin
            tgt = val_t'($urandom);
          end
          send_item(CMD_REQUEST, val_t'($urandom), stock_t'($urandom), tgt);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          raw_cmd = 2'($urandom_range(0, 3));
          send_item(cmd_t'(raw_cmd), val_t'($urandom), stock_t'($urandom),
                    val_t'($urandom));
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Stimulus and end of run
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_basic_set();
    test_full_table();
    test_backpressure();
    test_random_sessions();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("greedy_change_maker_limited_stock_core test passed");
    end else begin
      $display("greedy_change_maker_limited_stock_core test failed");
    end
    $finish;
  end

  // Output side: random ready gaps, plus a long hold when requested
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (rx_hold_req > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end else begin
        gap = pick_gap(rx_idle_en);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Compare each output transfer with the oldest expected record
  always @(posedge clk) begin
    change_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (change_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b",
                 $time, m_tdata, m_tlast);
        mismatch_cnt++;
      end else begin
        want = change_q.pop_front();
        if (m_tdata[2:0] !== want.idx) begin
          $display("%0t: entry_index mismatch, expected %0d, actual %0d",
                   $time, want.idx, m_tdata[2:0]);
          mismatch_cnt++;
        end
        if (m_tdata[10:3] !== want.used) begin
          $display("%0t: used_count mismatch, expected %0d, actual %0d",
                   $time, want.used, m_tdata[10:3]);
          mismatch_cnt++;
        end
        if (m_tdata[11] !== want.ok) begin
          $display("%0t: success mismatch, expected %b, actual %b",
                   $time, want.ok, m_tdata[11]);
          mismatch_cnt++;
        end
        if (m_tlast !== want.fin) begin
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.fin, m_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #10_000_000;
    $display("greedy_change_maker_limited_stock_core test failed");
    $finish;
  end

endmodule
